// File: sv/ssd_pkg.sv
// Shared types, constants, font tables and helpers for the seven-segment scan driver.
package ssd_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BIT_HALF   = 1'b0;
  localparam logic CFG_DIGIT_HOLD = 1'b1;

  // Defaults and fixed values.
  localparam int          DIGITS_DEF     = 4;
  localparam logic [15:0] BIT_HALF_RST   = 16'd16;
  localparam logic [15:0] DIGIT_HOLD_RST = 16'd16000;
  localparam logic [7:0]  SEG_BLANK      = 8'hFF;
  localparam logic [4:0]  FRAME_BITS     = 5'd16;

  // Active-low segment patterns for digits and letters.
  localparam logic [7:0] NUM_FONT [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam logic [7:0] ALPHA_FONT [26] = '{
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hCF, 8'hE1,
    8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h98, 8'hAF, 8'h92, 8'h87,
    8'hC1, 8'hC1, 8'hD5, 8'h89, 8'h91, 8'hA4
  };

  // Write or clear command for the segment store.
  typedef struct packed {
    logic       wr;
    logic       clr;
    logic [1:0] pos;
    logic [7:0] pattern;
  } store_cmd_t;

  // Width of an index into n entries, at least one bit.
  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Map an ASCII character to its segment pattern; anything unknown is blank.
  function automatic logic [7:0] font_lookup(logic [7:0] ch);
    logic [7:0] off;
    logic [7:0] res;
    res = SEG_BLANK;
    off = 8'h00;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      off = ch - 8'h30;
      res = NUM_FONT[off[3:0]];
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      off = ch - 8'h41;
      res = ALPHA_FONT[off[4:0]];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      off = ch - 8'h61;
      res = ALPHA_FONT[off[4:0]];
    end
    return res;
  endfunction

  // Digit-select byte: low digits pull up the high nibble, high digits the low one.
  function automatic logic [7:0] sel_byte(logic [2:0] d);
    logic [7:0] one_hot;
    one_hot = 8'h01 << d;
    return d[2] ? (8'h0F | one_hot) : (8'hF0 | one_hot);
  endfunction

endpackage

// File: sv/seven_segment_scan_driver.sv
// Top level of the multiplexed seven-segment scan driver: item stage, store and scan.
//
//   channel | ports                                         | transfer when
//   --------+-----------------------------------------------+-------------------------
//   input   | in_valid, in_stall, in_op, in_position,       | in_valid && !in_stall
//           | in_char_code                                  |
//   result  | out_valid, out_stall, out_serial_data,        | out_valid && !out_stall
//           | out_shift_clock, out_latch                    |
//   config  | cfg_wr_en, cfg_index, cfg_wdata               | cfg_wr_en
//
// One item per clock is taken unless the result stalls; its result is presented after the
// input register at the transfer, then the line-level register that doubles as the result.
// Reset is synchronous, active low; it blanks all digits and restarts the scan at digit 0.
// A stalled result holds the whole pipeline; in_stall rises only while both stages are full.
module seven_segment_scan_driver import ssd_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_position,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_serial_data,
  output logic        out_shift_clock,
  output logic        out_latch,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int DIG_W = idx_w(DIGITS);

  logic [15:0] bit_half_r;
  logic [15:0] digit_hold_r;

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [1:0]  s1_pos_r;
  logic [7:0]  s1_char_r;
  logic        out_valid_r;

  logic             advance;
  logic             exec;
  store_cmd_t       store_cmd;
  logic [DIG_W-1:0] digit_idx;
  logic [7:0]       pattern;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_half_r   <= BIT_HALF_RST;
      digit_hold_r <= DIGIT_HOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BIT_HALF:   bit_half_r   <= cfg_wdata;
        CFG_DIGIT_HOLD: digit_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the result register is empty or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign exec     = s1_valid_r && advance;

  // Input register and result valid; an empty input register fills even when stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance || !s1_valid_r) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_op;
      s1_pos_r  <= in_position;
      s1_char_r <= in_char_code;
    end
  end

  // Decode the item into a store command.
  always_comb begin
    store_cmd.wr      = exec && (s1_op_r == OP_WRITE);
    store_cmd.clr     = exec && (s1_op_r == OP_CLEAR);
    store_cmd.pos     = s1_pos_r;
    store_cmd.pattern = font_lookup(s1_char_r);
  end

  ssd_seg_store #(
    .DIGITS (DIGITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (store_cmd),
    .rd_idx     (digit_idx),
    .rd_pattern (pattern)
  );

  ssd_scan #(
    .DIGITS (DIGITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (exec && (s1_op_r == OP_TICK)),
    .bit_half    (bit_half_r),
    .digit_hold  (digit_hold_r),
    .pattern     (pattern),
    .digit_idx   (digit_idx),
    .serial_data (out_serial_data),
    .shift_clock (out_shift_clock),
    .latch       (out_latch)
  );

  assign out_valid = out_valid_r;

endmodule

// File: sv/ssd_seg_store.sv
// Per-digit segment pattern store with write, clear-all and one read port.
module ssd_seg_store import ssd_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  store_cmd_t                cmd,
  input  logic [idx_w(DIGITS)-1:0]  rd_idx,
  output logic [7:0]                rd_pattern
);

  logic [7:0] seg_r [DIGITS];

  // Clear blanks every digit; a write to a position past the last digit is dropped.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DIGITS; i++) begin
      if (!rst_n || cmd.clr) begin
        seg_r[i] <= SEG_BLANK;
      end else if (cmd.wr && int'(cmd.pos) == i) begin
        seg_r[i] <= cmd.pattern;
      end
    end
  end

  assign rd_pattern = seg_r[rd_idx];

endmodule

// File: sv/ssd_scan.sv
// Scan sequencer: latch, 16-bit serial shift and hold for each digit in turn.
module ssd_scan import ssd_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick_en,
  input  logic [15:0]               bit_half,
  input  logic [15:0]               digit_hold,
  input  logic [7:0]                pattern,
  output logic [idx_w(DIGITS)-1:0]  digit_idx,
  output logic                      serial_data,
  output logic                      shift_clock,
  output logic                      latch
);

  localparam int DIG_W = idx_w(DIGITS);
  localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(DIGITS - 1);

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_HOLD = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [DIG_W-1:0] digit_r, digit_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [15:0]      delay_r, delay_nxt;
  logic [15:0]      shift_r, shift_nxt;
  logic             data_r, data_nxt;
  logic             clk_r, clk_nxt;
  logic             latch_r, latch_nxt;

  logic [15:0] len_raw;
  logic [15:0] len_eff;
  logic [16:0] cnt_inc;
  logic        done;

  // Phase length check; a zero length counts as one tick.
  always_comb begin
    len_raw = (phase_r == PH_HOLD) ? digit_hold : bit_half;
    len_eff = (len_raw == 16'd0) ? 16'd1 : len_raw;
    cnt_inc = {1'b0, delay_r} + 17'd1;
    done    = cnt_inc >= {1'b0, len_eff};
  end

  // Next scan state and line levels for one tick.
  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    bit_nxt   = bit_r;
    delay_nxt = delay_r;
    shift_nxt = shift_r;
    data_nxt  = data_r;
    clk_nxt   = clk_r;
    latch_nxt = latch_r;
    if (tick_en) begin
      delay_nxt = done ? 16'd0 : cnt_inc[15:0];
      case (phase_r)
        PH_LOAD: begin
          shift_nxt = {pattern, sel_byte(3'(digit_r))};
          bit_nxt   = 5'd0;
          delay_nxt = 16'd0;
          latch_nxt = 1'b0;
          clk_nxt   = 1'b0;
          data_nxt  = pattern[7];
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          latch_nxt = 1'b0;
          clk_nxt   = 1'b1;
          data_nxt  = shift_r[15];
          if (done) phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          latch_nxt = 1'b0;
          clk_nxt   = 1'b0;
          data_nxt  = shift_r[15];
          if (done) begin
            shift_nxt = {shift_r[14:0], 1'b0};
            bit_nxt   = bit_r + 5'd1;
            phase_nxt = (bit_r + 5'd1 >= FRAME_BITS) ? PH_HOLD : PH_HIGH;
          end
        end
        default: begin
          latch_nxt = 1'b1;
          clk_nxt   = 1'b0;
          data_nxt  = shift_r[15];
          if (done) begin
            digit_nxt = (digit_r == LAST_DIGIT) ? '0 : digit_r + DIG_W'(1);
            phase_nxt = PH_LOAD;
          end
        end
      endcase
    end
  end

  // Scan state and the held line levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOAD;
      digit_r <= '0;
      bit_r   <= 5'd0;
      delay_r <= 16'd0;
      shift_r <= 16'd0;
      data_r  <= 1'b0;
      clk_r   <= 1'b0;
      latch_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
      bit_r   <= bit_nxt;
      delay_r <= delay_nxt;
      shift_r <= shift_nxt;
      data_r  <= data_nxt;
      clk_r   <= clk_nxt;
      latch_r <= latch_nxt;
    end
  end

  assign digit_idx   = digit_r;
  assign serial_data = data_r;
  assign shift_clock = clk_r;
  assign latch       = latch_r;

  // The latch is never raised while the shift clock is high.
  a_latch_clk: assert property (@(posedge clk) disable iff (!rst_n)
    latch_r |-> !clk_r) else $error("latch and shift clock high together");

  // All 16 bits have left the shifter by the time the hold phase starts.
  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HOLD |-> shift_r == 16'd0) else $error("shifter not empty in hold");

  // The bit counter never runs past one frame.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= FRAME_BITS) else $error("bit counter past frame");

  // The digit counter stays inside the display.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_r <= LAST_DIGIT) else $error("digit index out of range");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the seven-segment scan driver: a directed table, then random items.
module testbench;
  import ssd_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         NUM_DIGITS = 4;
  localparam int         DIR_ROWS   = 25;
  localparam int         IDLE_PCT   = 37;

  typedef enum logic [1:0] {SCAN_LOAD, SCAN_CLK_HI, SCAN_CLK_LO, SCAN_HOLD} scan_state_t;

  // Line levels carried by one result transfer.
  typedef struct packed {
    logic data;
    logic sclk;
    logic lat;
  } lines_t;

  // One row of the directed table; typed rows carry their expected lines.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] pos;
    logic [7:0] ch;
    logic       typed;
    lines_t     lines;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_WRITE;
  logic [1:0]  in_position = 2'd0;
  logic [7:0]  in_char_code = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_serial_data;
  logic        out_shift_clock;
  logic        out_latch;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_BIT_HALF;
  logic [15:0] cfg_wdata = 16'd0;

  // Mirror of the block's state and delay registers.
  logic [7:0]  seg_mirror [NUM_DIGITS];
  logic [1:0]  scan_digit;
  logic [4:0]  scan_bit;
  scan_state_t scan_state;
  logic [15:0] phase_cnt;
  logic [15:0] shift_word;
  lines_t      line_now;
  logic [15:0] half_len;
  logic [15:0] hold_len;

  lines_t   expected_lines [$];
  lines_t   got_lines;
  lines_t   want_lines;
  dir_row_t row;
  int       idle_pct = IDLE_PCT;
  int       mismatch_count = 0;
  int       results_checked = 0;
  int       items_sent = 0;
  int       ticks_sent = 0;
  int       writes_sent = 0;
  int       clears_sent = 0;
  int       settings_run = 0;

  seven_segment_scan_driver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_serial_data (out_serial_data),
    .out_shift_clock (out_shift_clock),
    .out_latch       (out_latch),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Active-low segment pattern of a character; letters fold to upper case.
  function automatic logic [7:0] glyph_of(logic [7:0] ch);
    logic [7:0] k;
    k = ch;
    if (ch >= "a" && ch <= "z") k = ch - 8'h20;
    case (k)
      "0": return 8'hC0;  "1": return 8'hF9;  "2": return 8'hA4;  "3": return 8'hB0;
      "4": return 8'h99;  "5": return 8'h92;  "6": return 8'h82;  "7": return 8'hF8;
      "8": return 8'h80;  "9": return 8'h90;
      "A": return 8'h88;  "B": return 8'h83;  "C": return 8'hC6;  "D": return 8'hA1;
      "E": return 8'h86;  "F": return 8'h8E;  "G": return 8'hC2;  "H": return 8'h89;
      "I": return 8'hCF;  "J": return 8'hE1;  "K": return 8'h8A;  "L": return 8'hC7;
      "M": return 8'hEA;  "N": return 8'hC8;  "O": return 8'hC0;  "P": return 8'h8C;
      "Q": return 8'h98;  "R": return 8'hAF;  "S": return 8'h92;  "T": return 8'h87;
      "U": return 8'hC1;  "V": return 8'hC1;  "W": return 8'hD5;  "X": return 8'h89;
      "Y": return 8'h91;  "Z": return 8'hA4;
      default: return SEG_BLANK;
    endcase
  endfunction

  // Count one tick of a delay phase; a zero length counts as one tick.
  function automatic logic count_phase(logic [15:0] length);
    logic [16:0] len;
    logic [16:0] next;
    len = (length == 16'd0) ? 17'd1 : {1'b0, length};
    next = {1'b0, phase_cnt} + 17'd1;
    if (next >= len) begin
      phase_cnt = 16'd0;
      return 1'b1;
    end
    phase_cnt = next[15:0];
    return 1'b0;
  endfunction

  // One step of the scan: latch low, 16 clocked bits, then latch hold.
  function automatic void advance_scan();
    case (scan_state)
      SCAN_LOAD: begin
        shift_word = {seg_mirror[scan_digit], 4'hF, 4'b0001 << scan_digit};
        scan_bit = 5'd0;
        phase_cnt = 16'd0;
        line_now = {shift_word[15], 2'b00};
        scan_state = SCAN_CLK_HI;
      end
      SCAN_CLK_HI: begin
        line_now = {shift_word[15], 2'b10};
        if (count_phase(half_len)) scan_state = SCAN_CLK_LO;
      end
      SCAN_CLK_LO: begin
        line_now = {shift_word[15], 2'b00};
        if (count_phase(half_len)) begin
          shift_word = shift_word << 1;
          scan_bit = scan_bit + 5'd1;
          scan_state = (scan_bit >= FRAME_BITS) ? SCAN_HOLD : SCAN_CLK_HI;
        end
      end
      default: begin
        line_now = {shift_word[15], 2'b01};
        if (count_phase(hold_len)) begin
          // Four digits, so the two-bit index wraps on its own.
          scan_digit = scan_digit + 2'd1;
          scan_state = SCAN_LOAD;
        end
      end
    endcase
  endfunction

  // Apply one item to the mirror and return the line levels it leaves.
  function automatic lines_t predict_lines(logic [1:0] op, logic [1:0] pos, logic [7:0] ch);
    case (op)
      OP_WRITE: seg_mirror[pos] = glyph_of(ch);
      OP_CLEAR: for (int i = 0; i < NUM_DIGITS; i++) seg_mirror[i] = SEG_BLANK;
      OP_TICK:  advance_scan();
      default:  ;
    endcase
    return line_now;
  endfunction

  // Directed stimulus: extremes, every op, font edges and writes during a scan.
  function automatic dir_row_t dir_row(int idx);
    case (idx)
      0:  return {OP_WRITE,  2'd0, 8'h00, 1'b1, 3'b000};
      1:  return {OP_WRITE,  2'd1, 8'hFF, 1'b1, 3'b000};
      2:  return {OP_WRITE,  2'd2, 8'h39, 1'b1, 3'b000};
      3:  return {OP_WRITE,  2'd3, 8'h5A, 1'b1, 3'b000};
      4:  return {OP_CLEAR,  2'd3, 8'hFF, 1'b1, 3'b000};
      5:  return {OP_UNUSED, 2'd3, 8'hFF, 1'b1, 3'b000};
      6:  return {OP_WRITE,  2'd0, 8'h30, 1'b0, 3'b000};
      7:  return {OP_WRITE,  2'd1, 8'h61, 1'b0, 3'b000};
      8:  return {OP_WRITE,  2'd2, 8'h7A, 1'b0, 3'b000};
      9:  return {OP_WRITE,  2'd3, 8'h20, 1'b0, 3'b000};
      10: return {OP_TICK,   2'd0, 8'h00, 1'b1, 3'b100};
      11: return {OP_TICK,   2'd3, 8'hFF, 1'b1, 3'b110};
      12: return {OP_TICK,   2'd0, 8'h00, 1'b0, 3'b000};
      13: return {OP_WRITE,  2'd0, 8'h41, 1'b0, 3'b000};
      14: return {OP_TICK,   2'd1, 8'h55, 1'b0, 3'b000};
      15: return {OP_UNUSED, 2'd0, 8'h00, 1'b0, 3'b000};
      16: return {OP_TICK,   2'd2, 8'hAA, 1'b0, 3'b000};
      17: return {OP_WRITE,  2'd1, 8'h2F, 1'b0, 3'b000};
      18: return {OP_WRITE,  2'd2, 8'h3A, 1'b0, 3'b000};
      19: return {OP_WRITE,  2'd3, 8'h40, 1'b0, 3'b000};
      20: return {OP_WRITE,  2'd0, 8'h5B, 1'b0, 3'b000};
      21: return {OP_WRITE,  2'd1, 8'h60, 1'b0, 3'b000};
      22: return {OP_WRITE,  2'd2, 8'h7B, 1'b0, 3'b000};
      23: return {OP_CLEAR,  2'd0, 8'h00, 1'b0, 3'b000};
      default: return {OP_TICK, 2'd1, 8'h31, 1'b0, 3'b000};
    endcase
  endfunction

  // Offer one item, wait for its transfer, then record what it should produce.
  task automatic send_item(input logic [1:0] op, input logic [1:0] pos, input logic [7:0] ch,
                           input logic typed, input lines_t typed_lines);
    lines_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_position <= pos;
    in_char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_lines(op, pos, ch);
    expected_lines.push_back(typed ? typed_lines : predicted);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
    if (op == OP_WRITE) writes_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // Stop offering items and wait until every result has been checked.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write, then the write enable is dropped before the task returns.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_BIT_HALF) half_len = value;
    else hold_len = value;
  endtask

  // Mostly ticks so the scan gets deep, mixed with writes, clears and unused ops.
  task automatic random_item();
    logic [1:0] op;
    logic [7:0] ch;
    int         r;
    r = $urandom_range(99);
    if (r < 62) op = OP_TICK;
    else if (r < 85) op = OP_WRITE;
    else if (r < 92) op = OP_CLEAR;
    else op = OP_UNUSED;
    r = $urandom_range(99);
    if (r < 40) ch = 8'h30 + 8'($urandom_range(9));
    else if (r < 80) ch = ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
    else ch = 8'($urandom);
    send_item(op, 2'($urandom_range(3)), ch, 1'b0, 3'b000);
  endtask

  // One delay setting, written while idle, followed by a run of random items.
  task automatic run_phase(input logic [15:0] half, input logic [15:0] hold,
                           input int count, input int pct);
    drain_pipeline();
    write_reg(CFG_BIT_HALF, half);
    write_reg(CFG_DIGIT_HOLD, hold);
    idle_pct = pct;
    repeat (count) random_item();
    settings_run++;
  endtask

  // Result side: check each transfer against the oldest expectation, stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_lines = {out_serial_data, out_shift_clock, out_latch};
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result data=%b clock=%b latch=%b with nothing expected",
                   got_lines.data, got_lines.sclk, got_lines.lat);
      end else begin
        want_lines = expected_lines.pop_front();
        results_checked++;
        if (got_lines !== want_lines) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d expected data=%b clock=%b latch=%b, got %b %b %b",
                     results_checked, want_lines.data, want_lines.sclk, want_lines.lat,
                     got_lines.data, got_lines.sclk, got_lines.lat);
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Main sequence: reset, directed table with zero delays, then the random settings.
  initial begin
    for (int i = 0; i < NUM_DIGITS; i++) seg_mirror[i] = SEG_BLANK;
    scan_digit = 2'd0;
    scan_bit = 5'd0;
    scan_state = SCAN_LOAD;
    phase_cnt = 16'd0;
    shift_word = 16'd0;
    line_now = 3'b000;
    half_len = BIT_HALF_RST;
    hold_len = DIGIT_HOLD_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Zero delays are taken as one tick, which keeps the directed scan short.
    write_reg(CFG_BIT_HALF, 16'd0);
    write_reg(CFG_DIGIT_HOLD, 16'd0);
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      send_item(row.op, row.pos, row.ch, row.typed, row.lines);
    end

    run_phase(16'd1, 16'd1, 250, IDLE_PCT);
    run_phase(16'd2, 16'd3, 250, IDLE_PCT);
    run_phase(16'd1, 16'd40, 200, IDLE_PCT);
    run_phase(16'd3, 16'd1, 200, 0);
    run_phase(16'd65535, 16'd65535, 120, IDLE_PCT);
    run_phase(16'd65535, 16'd1, 80, IDLE_PCT);
    run_phase(BIT_HALF_RST, DIGIT_HOLD_RST, 100, IDLE_PCT);
    run_phase(16'd1, 16'd65535, 150, IDLE_PCT);
    run_phase(16'd5, 16'd2, 200, IDLE_PCT);

    drain_pipeline();
    repeat (20) @(posedge clk);

    $display("Ran %0d items (%0d ticks, %0d writes, %0d clears) across %0d delay settings.",
             items_sent, ticks_sent, writes_sent, clears_sent, settings_run + 1);
    $display("Compared %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("seven_segment_scan_driver verification clean");
    end else begin
      $display("seven_segment_scan_driver verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(12 * 300000);
    $display("seven_segment_scan_driver verification failed");
    $finish;
  end

endmodule
